[src/sth_pkg.sv]
package sth_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_TREE_HEIGHT = 8;
   localparam int DEF_VALUE_BITS  = 32;
   localparam int DEF_COUNT_BITS  = 32;

   // Fixed field widths and limits
   localparam int MAX_TREE_HEIGHT = 10;
   localparam int SLOT_BITS       = 8;
   localparam int COUNT_OUT_BITS  = 32;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      FUNC_LOAD     = 2'd0,
      FUNC_CLASSIFY = 2'd1,
      FUNC_READ     = 2'd2,
      FUNC_CLEAR    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      BOP_INC,
      BOP_READ,
      BOP_CLEAR
   } back_op_type;

   typedef enum logic {
      FS_IDLE,
      FS_WALK
   } front_state_type;

   typedef enum logic [1:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_FETCH,
      BS_SEND
   } back_state_type;

   typedef struct packed {
      back_op_type                op;
      logic [MAX_TREE_HEIGHT-1:0] addr;      // count memory address
      logic [SLOT_BITS-1:0]       tag;       // bucket field of the response
      logic                       in_range;  // read slot hits a real bucket
   } job_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

[src/sth_if.sv]
interface sth_req_if
   import sth_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [SLOT_BITS-1:0]  slot;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, func, slot, value, input ready);
   modport sink   (input valid, func, slot, value, output ready);
endinterface

interface sth_rsp_if
   import sth_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [SLOT_BITS-1:0]      bucket;
   logic [COUNT_OUT_BITS-1:0] count;

   modport source (output valid, bucket, count, input ready);
   modport sink   (input valid, bucket, count, output ready);
endinterface

[src/sth_ram.sv]
module sth_ram #(
   parameter  int WIDTH     = 32,
   parameter  int DEPTH     = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sth_queue.sv]
module sth_queue
   import sth_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_BITS + 1)'(do_push) - (QPTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = entries_ff[rd_ptr_ff];

endmodule

[src/sth_front.sv]
module sth_front
   import sth_pkg::*;
#(
   parameter int TREE_HEIGHT = DEF_TREE_HEIGHT,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic            clock,
   input  logic            reset,
   sth_req_if.sink         req_if,
   input  back_status_type back_status,
   input  logic            queue_full,
   output logic            push_valid,
   output job_type         push_job
);

   localparam int AW         = TREE_HEIGHT;
   localparam int LW         = (TREE_HEIGHT > 1) ? $clog2(TREE_HEIGHT) : 1;
   localparam int TREE_WIDTH = 1 << TREE_HEIGHT;
   localparam int TREE_INNER = TREE_WIDTH - 1;
   localparam int EXP_BITS   = (VALUE_BITS == 64) ? 11 : ((VALUE_BITS == 16) ? 5 : 8);
   localparam int MANT_BITS  = VALUE_BITS - 1 - EXP_BITS;

   localparam logic [VALUE_BITS-1:0] SIGN_MASK = {1'b1, {(VALUE_BITS - 1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] EXP_MASK  =
      {1'b0, {EXP_BITS{1'b1}}, {MANT_BITS{1'b0}}};

   function automatic logic is_nan(input logic [VALUE_BITS-1:0] x);
      return ((x & EXP_MASK) == EXP_MASK) && ((x & ~EXP_MASK & ~SIGN_MASK) != '0);
   endfunction

   // maps IEEE order onto unsigned order
   function automatic logic [VALUE_BITS-1:0] order_key(input logic [VALUE_BITS-1:0] x);
      return x[VALUE_BITS-1] ? ~x : (x | SIGN_MASK);
   endfunction

   function automatic logic fp_less(input logic [VALUE_BITS-1:0] a,
                                    input logic [VALUE_BITS-1:0] b);
      logic res;
      if (is_nan(a) || is_nan(b)) begin
         res = 1'b0;
      end else if (((a | b) & ~SIGN_MASK) == '0) begin
         res = 1'b0;  // +0 and -0 are equal
      end else begin
         res = order_key(a) < order_key(b);
      end
      return res;
   endfunction

   front_state_type       state_ff, state_in;
   logic [LW-1:0]         level_ff, level_in;
   logic [AW-1:0]         node_ff, node_in;
   logic [VALUE_BITS-1:0] elem_ff, elem_in;

   logic                  accept;
   func_type              func;
   logic [VALUE_BITS-1:0] split_rd;
   logic                  step_right;
   logic [AW:0]           node_next;
   logic [AW-1:0]         bucket_idx;
   logic                  last_level;
   logic                  tree_wr_en;
   logic [AW-1:0]         tree_rd_addr;

   assign func   = func_type'(req_if.func);
   assign accept = req_if.valid && req_if.ready;

   assign step_right = !fp_less(elem_ff, split_rd);
   assign node_next  = {node_ff, 1'b0} + (AW + 1)'(1) + (AW + 1)'(step_right);
   assign bucket_idx = AW'(node_next - (AW + 1)'(TREE_INNER));
   assign last_level = (level_ff == LW'(TREE_HEIGHT - 1));

   sth_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TREE_INNER)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (AW'(req_if.slot)),
      .wr_data (req_if.value),
      .rd_addr (tree_rd_addr),
      .rd_data (split_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept && func == FUNC_CLASSIFY) begin
               state_in = FS_WALK;
            end
         end
         FS_WALK: begin
            if (last_level) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_if.ready = (state_ff == FS_IDLE) && !queue_full && !back_status.clearing;
      tree_wr_en   = accept && func == FUNC_LOAD &&
                     (32'(req_if.slot) < 32'(TREE_INNER));
      tree_rd_addr = '0;
      level_in     = level_ff;
      node_in      = node_ff;
      elem_in      = elem_ff;
      push_valid   = 1'b0;
      push_job     = '{op: BOP_CLEAR, addr: '0, tag: '0, in_range: 1'b0};
      case (state_ff)
         FS_IDLE: begin
            level_in = '0;
            node_in  = '0;
            if (accept) begin
               elem_in = req_if.value & ~SIGN_MASK;
            end
            if (accept && func == FUNC_READ) begin
               push_valid = 1'b1;
               push_job   = '{op: BOP_READ, addr: MAX_TREE_HEIGHT'(req_if.slot),
                              tag: req_if.slot,
                              in_range: (32'(req_if.slot) < 32'(TREE_WIDTH))};
            end else if (accept && func == FUNC_CLEAR) begin
               push_valid = 1'b1;
            end
         end
         FS_WALK: begin
            tree_rd_addr = node_next[AW-1:0];
            level_in     = level_ff + LW'(1);
            node_in      = node_next[AW-1:0];
            if (last_level) begin
               push_valid = 1'b1;
               push_job   = '{op: BOP_INC, addr: MAX_TREE_HEIGHT'(bucket_idx),
                              tag: SLOT_BITS'(bucket_idx), in_range: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      node_ff  <= node_in;
      elem_ff  <= elem_in;
   end

endmodule

[src/sth_back.sv]
module sth_back
   import sth_pkg::*;
#(
   parameter int TREE_HEIGHT = DEF_TREE_HEIGHT,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  job_type         head_job,
   input  logic            queue_empty,
   output logic            pop,
   output back_status_type back_status,
   sth_rsp_if.source       rsp_if
);

   localparam int AW         = TREE_HEIGHT;
   localparam int TREE_WIDTH = 1 << TREE_HEIGHT;

   back_state_type            state_ff, state_in;
   logic [AW-1:0]             clr_ff, clr_in;
   job_type                   job_ff, job_in;
   logic [SLOT_BITS-1:0]      bucket_ff, bucket_in;
   logic [COUNT_OUT_BITS-1:0] count_ff, count_in;

   logic [COUNT_BITS-1:0]     cnt_rd;
   logic [COUNT_BITS-1:0]     cnt_sat;
   logic                      cnt_wr_en;
   logic [AW-1:0]             cnt_wr_addr;
   logic [COUNT_BITS-1:0]     cnt_wr_data;

   assign cnt_sat = (cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_BITS'(1);

   sth_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TREE_WIDTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (head_job.addr[AW-1:0]),
      .rd_data (cnt_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (!queue_empty) begin
               state_in = (head_job.op == BOP_CLEAR) ? BS_CLEAR : BS_FETCH;
            end
         end
         BS_FETCH: state_in = BS_SEND;
         BS_SEND: begin
            if (rsp_if.ready) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop                  = (state_ff == BS_IDLE) && !queue_empty;
      back_status.clearing = (state_ff == BS_CLEAR);
      rsp_if.valid         = (state_ff == BS_SEND);
      rsp_if.bucket        = bucket_ff;
      rsp_if.count         = count_ff;
      clr_in               = (state_ff == BS_CLEAR) ? clr_ff + AW'(1) : '0;
      job_in               = pop ? head_job : job_ff;
      bucket_in            = bucket_ff;
      count_in             = count_ff;
      cnt_wr_en            = 1'b0;
      cnt_wr_addr          = job_ff.addr[AW-1:0];
      cnt_wr_data          = cnt_sat;
      case (state_ff)
         BS_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
         end
         BS_FETCH: begin
            bucket_in = job_ff.tag;
            if (job_ff.op == BOP_INC) begin
               cnt_wr_en = 1'b1;
               count_in  = COUNT_OUT_BITS'(cnt_sat);
            end else begin
               count_in  = job_ff.in_range ? COUNT_OUT_BITS'(cnt_rd) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      bucket_ff <= bucket_in;
      count_ff  <= count_in;
   end

endmodule

[src/splitter_tree_bucket_histogram.sv]
// Channel   Dir  Beat payload               Notes
// req_if    in   func, slot, value          load / classify / read / clear
// rsp_if    out  bucket, count              classify and read only
//
// Classify: the front walks the tree in FS_WALK, one tree level at a time, paced by
//   the splitter RAM's registered read port. Load, read, clear: taken in FS_IDLE, no walk.
// Count update and read in the back: count RAM read, update, send (IDLE, FETCH, SEND).
// Clear sweeps the count RAM, one bucket a cycle, over every bucket.
// Reset: the same sweep runs first; req_if.ready stays low while it runs. A stalled
//   rsp_if holds the back; the front keeps filling the two-entry job queue and
//   stalls only when it is full.
module splitter_tree_bucket_histogram
   import sth_pkg::*;
#(
   parameter int TREE_HEIGHT = DEF_TREE_HEIGHT,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic      clock,
   input  logic      reset,
   sth_req_if.sink   req_if,
   sth_rsp_if.source rsp_if
);

   // front -> queue -> back
   logic            push_valid;
   job_type         push_job;
   logic            pop;
   job_type         head_job;
   logic            queue_empty;
   logic            queue_full;
   back_status_type back_status;

   // front: accepts beats, writes splitters, walks the tree
   sth_front #(
      .TREE_HEIGHT (TREE_HEIGHT),
      .VALUE_BITS  (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .back_status (back_status),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // short job queue decouples the tree walk from count updates
   sth_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // back: count RAM read-modify-write, clear sweep, response register
   sth_back #(
      .TREE_HEIGHT (TREE_HEIGHT),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .back_status (back_status),
      .rsp_if      (rsp_if)
   );

   // space is reserved at accept, so a push never meets a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("job pushed into full queue");

   // the count sweep starts right out of reset
   a_boot_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> back_status.clearing)
      else $error("no clear sweep after reset");

   // no beat taken while counts are being cleared
   a_hold_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !req_if.ready)
      else $error("request accepted during clear sweep");

   // classify jobs report the bucket they update
   a_inc_tag: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_job.op == BOP_INC |-> push_job.tag == SLOT_BITS'(push_job.addr))
      else $error("classify bucket tag mismatch");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

// Bench for the splitter-tree bucket histogram.
// A scoreboard-style predictor mirrors the splitter tree and the bucket counts.
// Every accepted request updates it in order, and every classify or read queues
// one expected beat. The checker compares each accepted response beat against
// the oldest queued expectation.
module tb
   import sth_pkg::*;
;

   localparam int TREE_HEIGHT = DEF_TREE_HEIGHT;
   localparam int VALUE_BITS  = DEF_VALUE_BITS;
   localparam int COUNT_BITS  = DEF_COUNT_BITS;
   localparam int NUM_BUCKETS = 1 << TREE_HEIGHT;
   localparam int TREE_INNER  = NUM_BUCKETS - 1;

   // Idle time after the last response: a clear sweep touches every bucket
   localparam int SETTLE_CYCLES = NUM_BUCKETS + 64;
   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 240;

   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   typedef struct packed {
      logic [SLOT_BITS-1:0]      bucket;
      logic [COUNT_OUT_BITS-1:0] count;
   } bucket_result_type;

   logic clock;
   logic reset;

   sth_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   sth_rsp_if rsp_ch ();

   splitter_tree_bucket_histogram #(
      .TREE_HEIGHT(TREE_HEIGHT),
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Predictor state: splitter tree copy, bucket counts, expected beats
   // ------------------------------------------------------------------
   logic [31:0]         splitters [0:TREE_INNER-1];
   logic [31:0]         hist      [0:NUM_BUCKETS-1];
   bucket_result_type   pending_beats [$];
   logic [SLOT_BITS-1:0] last_bucket;

   int n_errors;
   int n_loads;
   int n_classifies;
   int n_reads;
   int n_clears;
   int n_checked;
   int n_long_holds;

   // Idle knobs for the sender and the receiver
   bit req_idle_on;
   bit rsp_idle_on;
   int hold_request;   // receiver picks this up and holds ready low that long

   function automatic bit is_nan32(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 23'd0;
   endfunction

   // Total order of non-NaN floats as unsigned keys (-0 sits just below +0)
   function automatic logic [31:0] order_of(logic [31:0] x);
      return x[31] ? ~x : {1'b1, x[30:0]};
   endfunction

   // IEEE less-than: false on any NaN, and +0 / -0 compare equal
   function automatic bit float_below(logic [31:0] a, logic [31:0] b);
      if (is_nan32(a) || is_nan32(b))
         return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
         return 1'b0;
      return order_of(a) < order_of(b);
   endfunction

   // Update the predictor for one accepted request beat
   function automatic void apply_request(func_type f, logic [7:0] s, logic [31:0] v);
      bucket_result_type res;
      logic [31:0]       elem;
      int                node;
      case (f)
         FUNC_LOAD: begin
            if (s < TREE_INNER)
               splitters[s] = v;
            n_loads++;
         end
         FUNC_CLASSIFY: begin
            elem = v & ~SIGN_MASK;
            node = 0;
            for (int lvl = 0; lvl < TREE_HEIGHT; lvl++)
               node = 2 * node + (float_below(elem, splitters[node]) ? 1 : 2);
            res.bucket = SLOT_BITS'(node - TREE_INNER);
            if (hist[res.bucket] != '1)
               hist[res.bucket] = hist[res.bucket] + 1;
            res.count = hist[res.bucket];
            last_bucket = res.bucket;
            pending_beats.push_back(res);
            n_classifies++;
         end
         FUNC_READ: begin
            res.bucket = s;
            res.count  = (s < NUM_BUCKETS) ? hist[s] : '0;
            pending_beats.push_back(res);
            n_reads++;
         end
         default: begin
            foreach (hist[i])
               hist[i] = '0;
            n_clears++;
         end
      endcase
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(bit on);
      int r;
      if (!on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] special_value();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;   // +0
         1:       return 32'h8000_0000;   // -0
         2:       return 32'h7F80_0000;   // +inf
         3:       return 32'hFF80_0000;   // -inf
         4:       return 32'h7FC0_0000;   // quiet NaN
         5:       return 32'hFFFF_FFFF;   // NaN with sign
         6:       return 32'h0000_0001;   // smallest denormal
         7:       return 32'h007F_FFFF;   // largest denormal
         8:       return 32'h7F7F_FFFF;   // largest normal
         default: return 32'h7F80_0001;   // signaling NaN
      endcase
   endfunction

   // Element to classify: mostly right around a stored splitter
   function automatic logic [31:0] pick_element();
      int          r;
      logic [31:0] mag;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         mag = splitters[$urandom_range(0, TREE_INNER - 1)] & ~SIGN_MASK;
         mag = mag + $urandom_range(0, 4) - 2;
         return {1'($urandom_range(0, 1)), mag[30:0]};
      end
      if (r < 90)
         return $urandom;
      return special_value();
   endfunction

   // Stray splitter overwrite: any class of value, sign as written
   function automatic logic [31:0] pick_splitter();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(0, 32'h7F7F_FFFF);
      if (r < 75)
         return $urandom;
      if (r < 85)
         return {1'b1, 31'($urandom)};
      return special_value();
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Request side. Entered and left at a falling edge; valid stays up
   // across back-to-back beats.
   // ------------------------------------------------------------------
   task automatic send_beat(func_type f, logic [7:0] s, logic [31:0] v);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= f;
      req_ch.slot  <= s;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      apply_request(f, s, v);
      @(negedge clock);
   endtask

   // Drop valid, wait out every expected beat, then let any clear sweep finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Full tree load. Ascending magnitudes placed in-order so the tree is a
   // proper search tree; heap node n at level d, position p holds rank
   // (2p+1) * 2^(H-1-d) - 1. With scramble the values are just random.
   task automatic load_sorted_tree(bit scramble);
      logic [31:0] ordered [0:TREE_INNER-1];
      logic [31:0] pat;
      int unsigned step_max;
      int          lvl;
      int          pos;
      int          rank;
      step_max = 1 << $urandom_range(0, 20);
      pat = $urandom_range(0, 32'h4F00_0000);
      for (int r = 0; r < TREE_INNER; r++) begin
         pat = pat + $urandom_range(1, step_max);
         ordered[r] = scramble ? 32'($urandom) : pat;
      end
      for (int n = 0; n < TREE_INNER; n++) begin
         lvl = 0;
         while ((2 << lvl) <= n + 1)
            lvl++;
         pos  = n + 1 - (1 << lvl);
         rank = (2 * pos + 1) * (1 << (TREE_HEIGHT - 1 - lvl)) - 1;
         send_beat(FUNC_LOAD, 8'(n), ordered[rank]);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: ready pattern set at the falling edge, beats checked
   // at the rising edge.
   // ------------------------------------------------------------------
   initial begin
      int hold_left;
      int stall_left;
      int g;
      hold_left  = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request > 0) begin
            // long hold-off, counted here cycle by cycle
            rsp_ch.ready <= 1'b0;
            hold_left    = hold_request - 1;
            hold_request = 0;
         end else if (!rsp_idle_on) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            g = pick_gap(1'b1);
            if (g > 0) begin
               rsp_ch.ready <= 1'b0;
               stall_left = g - 1;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   bucket_result_type want_beat;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat (bucket)", 32'(rsp_ch.bucket), 32'hFFFF_FFFF);
         end else begin
            want_beat = pending_beats.pop_front();
            if (rsp_ch.bucket !== want_beat.bucket)
               report_mismatch("bucket", 32'(rsp_ch.bucket), 32'(want_beat.bucket));
            if (rsp_ch.count !== want_beat.count)
               report_mismatch("count", rsp_ch.count, want_beat.count);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Counts come out of reset at zero; reads wait behind the reset sweep
   task automatic test_reset_counts();
      send_beat(FUNC_READ, 8'd0, 32'hFFFF_FFFF);
      send_beat(FUNC_READ, 8'd255, 32'h0000_0000);
      send_beat(FUNC_READ, 8'($urandom_range(1, 254)), $urandom);
   endtask

   // Known tree: rank r holds 3F80_0000 + r * 2^16 (1.0 + r * 2^-7 below rank 128), so rank 127 is at the root
   task automatic test_tree_load();
      int lvl;
      int pos;
      int rank;
      for (int n = 0; n < TREE_INNER; n++) begin
         lvl = 0;
         while ((2 << lvl) <= n + 1)
            lvl++;
         pos  = n + 1 - (1 << lvl);
         rank = (2 * pos + 1) * (1 << (TREE_HEIGHT - 1 - lvl)) - 1;
         send_beat(FUNC_LOAD, 8'(n), 32'h3F80_0000 + 32'(rank) * 32'h0001_0000);
      end
   endtask

   task automatic test_special_values();
      logic [31:0] root_val;
      root_val = splitters[0];
      send_beat(FUNC_CLASSIFY, 8'd0,   32'h0000_0000);   // below every splitter
      send_beat(FUNC_CLASSIFY, 8'd255, 32'h8000_0000);   // -0 lands with +0
      send_beat(FUNC_CLASSIFY, 8'd17,  32'h0000_0001);
      send_beat(FUNC_CLASSIFY, 8'd0,   32'h7F80_0000);   // +inf: rightmost
      send_beat(FUNC_CLASSIFY, 8'd0,   32'hFF80_0000);   // -inf loses its sign
      send_beat(FUNC_CLASSIFY, 8'd0,   32'h7FC0_0000);   // NaN always steps right
      send_beat(FUNC_CLASSIFY, 8'd0,   32'hFFFF_FFFF);
      send_beat(FUNC_CLASSIFY, 8'd0,   root_val);        // equal goes right
      send_beat(FUNC_CLASSIFY, 8'd0,   root_val - 1);    // just below goes left
      send_beat(FUNC_CLASSIFY, 8'd0,   root_val | SIGN_MASK);
      send_beat(FUNC_READ, 8'd0,   32'd0);
      send_beat(FUNC_READ, 8'd255, 32'd0);
      send_beat(FUNC_READ, 8'd128, 32'd0);
      send_beat(FUNC_READ, 8'hAA,  32'd0);
      // load past the last inner node is dropped
      send_beat(FUNC_LOAD, 8'd255, 32'h0000_0000);
      send_beat(FUNC_CLASSIFY, 8'd0, 32'h3F80_0000);
      // -0 splitter at the root: +0 is not below it
      send_beat(FUNC_LOAD, 8'd0, 32'h8000_0000);
      send_beat(FUNC_CLASSIFY, 8'd0, 32'h0000_0000);
      // NaN splitter: every compare fails, step right
      send_beat(FUNC_LOAD, 8'd0, 32'h7FC0_0001);
      send_beat(FUNC_CLASSIFY, 8'd0, 32'h0000_0005);
      // negative splitter: all magnitudes sit at or above it
      send_beat(FUNC_LOAD, 8'd0, 32'hBF80_0000);
      send_beat(FUNC_CLASSIFY, 8'd0, 32'h3F00_0000);
      send_beat(FUNC_LOAD, 8'd0, root_val);
      send_beat(FUNC_CLEAR, 8'd0, 32'd0);
      send_beat(FUNC_READ, 8'd255, 32'd0);
   endtask

   // Receiver stalls for a long stretch while requests keep coming
   task automatic test_backpressure();
      settle();
      req_idle_on  = 1'b0;
      hold_request = 400;
      n_long_holds++;
      for (int i = 0; i < 40; i++)
         send_beat(FUNC_CLASSIFY, 8'($urandom), pick_element());
      req_idle_on = 1'b1;
      settle();
   endtask

   task automatic random_request();
      int          r;
      int          reps;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 62) begin
         send_beat(FUNC_CLASSIFY, 8'($urandom), pick_element());
      end else if (r < 66) begin
         // same element back to back: repeated increments of one bucket
         v    = pick_element();
         reps = $urandom_range(2, 6);
         for (int k = 0; k < reps; k++)
            send_beat(FUNC_CLASSIFY, 8'($urandom), v);
      end else if (r < 84) begin
         if ($urandom_range(0, 1))
            send_beat(FUNC_READ, last_bucket, $urandom);
         else
            send_beat(FUNC_READ, 8'($urandom), $urandom);
      end else if (r < 97) begin
         send_beat(FUNC_LOAD, 8'($urandom_range(0, 255)), pick_splitter());
      end else begin
         send_beat(FUNC_CLEAR, 8'($urandom), $urandom);
      end
   endtask

   task automatic test_random_mix();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // idle pattern per phase: both, none, sender only, receiver only
         req_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
         rsp_idle_on = (ph % 4 == 0) || (ph % 4 == 3);
         if (ph % 2 == 0)
            load_sorted_tree($urandom_range(0, 7) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_request();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_LOAD;
      req_ch.slot  = '0;
      req_ch.value = '0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      hold_request = 0;
      last_bucket  = '0;
      n_errors     = 0;
      n_loads      = 0;
      n_classifies = 0;
      n_reads      = 0;
      n_clears     = 0;
      n_checked    = 0;
      n_long_holds = 0;
      foreach (splitters[i])
         splitters[i] = '0;
      foreach (hist[i])
         hist[i] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_counts();
      test_tree_load();
      test_special_values();
      test_backpressure();
      test_random_mix();
      settle();

      $display("Covered %0d loads, %0d classifies, %0d reads, %0d clears;",
               n_loads, n_classifies, n_reads, n_clears);
      $display("%0d response beats checked, %0d long receiver hold-offs, %0d mismatches.",
               n_checked, n_long_holds, n_errors);
      if (n_errors == 0) begin
         $display("** splitter_tree_bucket_histogram: PASSED **");
      end else begin
         $display("** splitter_tree_bucket_histogram: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout: %0d response beats still expected.", pending_beats.size());
      $display("** splitter_tree_bucket_histogram: FAILED **");
      $finish;
   end

endmodule
